@@ src/sparse_coo_complex_matmul_assert.svh @@
// Assertion macros for the sparse COO matmul checker.
// The enclosing scope must provide clk and arst_n.
`ifndef SPARSE_COO_COMPLEX_MATMUL_ASSERT_SVH
`define SPARSE_COO_COMPLEX_MATMUL_ASSERT_SVH

// Same-cycle implication
`define SCOO_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SCOO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/scoo_pkg.sv @@
`timescale 1ns / 1ps

package scoo_pkg;

	// Store geometry and number format
	localparam int STORE_DEPTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// Input command codes
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_MULT   = 2'd2
	} cmd_t;

	// Result kind codes
	typedef enum logic [1:0] {
		KIND_STORED  = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_PRODUCT = 2'd2
	} kind_t;

	// One right-operand entry as held in the store
	typedef struct packed {
		logic [15:0]        row;
		logic [15:0]        col;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} entry_t;

endpackage

@@ src/scoo_if.sv @@
`timescale 1ns / 1ps

// Input channel: one command beat
interface scoo_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [15:0]        row;
	logic [15:0]        col;
	logic signed [31:0] real_part;
	logic signed [31:0] imag_part;

	modport source (output valid, command, row, col, real_part, imag_part, input ready);
	modport sink   (input valid, command, row, col, real_part, imag_part, output ready);
endinterface

// Output channel: one result beat
interface scoo_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [15:0]        out_row;
	logic [15:0]        out_col;
	logic signed [31:0] out_real;
	logic signed [31:0] out_imag;
	logic               last;

	modport source (output valid, kind, out_row, out_col, out_real, out_imag, last, input ready);
	modport sink   (input valid, kind, out_row, out_col, out_real, out_imag, last, output ready);
endinterface

@@ src/sparse_coo_complex_matmul.sv @@
`timescale 1ns / 1ps

// Sparse complex matrix multiply on COO entries, Q16.16 values.
// in_ch takes command beats: clear empties the store, append writes one
// right-operand entry (row, col, value), multiply streams one left entry.
// out_ch gives result beats: append answers with one stored or store-full
// beat; multiply answers with one product beat per stored entry whose row
// equals the left column, in store order, last set on the final one.
// A multiply with no match and a clear give no beat.
// Multiply uses the single 32x32 multiplier four times per match.
// in_ch is ready only while the sequencer is idle, one command at a time.
// Results leave through one output register; while the receiver stalls
// the sequencer holds one finished product and waits.
// Reset empties the store and drops any beat in flight; store contents are
// not cleared and no clearing pass is needed.
module sparse_coo_complex_matmul (
	input  logic        clk,
	input  logic        arst_n,
	scoo_in_if.sink     in_ch,
	scoo_out_if.source  out_ch
);

	localparam int IDX_W = scoo_pkg::IDX_W;
	localparam int CNT_W = scoo_pkg::CNT_W;
	localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
	localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CMP   = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_SAT   = 7'b0001000,
		ST_PUSH  = 7'b0010000,
		ST_FLUSH = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	// Arithmetic shift by the fraction width, then clamp to 32 bits
	function automatic logic signed [31:0] shift_sat(input logic signed [64:0] x);
		logic signed [64:0] sh;
		sh = x >>> scoo_pkg::FRAC_BITS;
		if (sh > SAT_MAX) begin
			return 32'sh7FFF_FFFF;
		end else if (sh < SAT_MIN) begin
			return 32'sh8000_0000;
		end
		return sh[31:0];
	endfunction

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [2:0] step_q;

	logic [15:0] a_row_q, a_col_q;
	logic signed [31:0] ar_q, ai_q;
	scoo_pkg::kind_t resp_kind_q;

	scoo_pkg::entry_t mem [scoo_pkg::STORE_DEPTH];
	scoo_pkg::entry_t rd_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_s1;
	logic signed [64:0] acc_re_q, acc_im_q;
	logic signed [31:0] res_re_q, res_im_q;

	logic pend_valid_q;
	logic [15:0] pend_col_q;
	logic signed [31:0] pend_re_q, pend_im_q;

	logic out_valid_q;
	scoo_pkg::kind_t out_kind_q;
	logic [15:0] out_row_q, out_col_q;
	logic signed [31:0] out_real_q, out_imag_q;
	logic out_last_q;

	logic in_acc, full, match, is_end, slot_free;
	logic advance, pend_load, load_out;
	scoo_pkg::kind_t ld_kind;
	logic [15:0] ld_row, ld_col;
	logic signed [31:0] ld_re, ld_im;
	logic ld_last;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign full        = (cnt_q == CNT_W'(scoo_pkg::STORE_DEPTH));
	assign match       = (rd_q.row == a_col_q);
	assign is_end      = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign slot_free   = !out_valid_q || out_ch.ready;

	// Sequencer
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		advance   = 1'b0;
		pend_load = 1'b0;
		load_out  = 1'b0;
		ld_kind   = scoo_pkg::KIND_PRODUCT;
		ld_row    = a_row_q;
		ld_col    = pend_col_q;
		ld_re     = pend_re_q;
		ld_im     = pend_im_q;
		ld_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_ch.command)
						scoo_pkg::CMD_APPEND: state_d = ST_RESP;
						scoo_pkg::CMD_MULT: begin
							idx_d = '0;
							if (cnt_q != '0) begin
								state_d = ST_CMP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_CMP: begin
				if (match) begin
					state_d = ST_MUL;
				end else begin
					advance = 1'b1;
				end
			end
			ST_MUL: begin
				if (step_q == 3'd4) begin
					state_d = ST_SAT;
				end
			end
			ST_SAT: state_d = ST_PUSH;
			ST_PUSH: begin
				// older product goes out before the new one takes its place
				if (!pend_valid_q || slot_free) begin
					pend_load = 1'b1;
					load_out  = pend_valid_q;
					advance   = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					load_out = 1'b1;
					ld_last  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					load_out = 1'b1;
					ld_kind  = resp_kind_q;
					ld_row   = '0;
					ld_col   = '0;
					ld_re    = '0;
					ld_im    = '0;
					ld_last  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// step to the next stored entry or finish the scan
		if (advance) begin
			if (is_end) begin
				state_d = (pend_valid_q || pend_load) ? ST_FLUSH : ST_IDLE;
			end else begin
				idx_d   = idx_q + IDX_W'(1);
				state_d = ST_CMP;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (in_acc && in_ch.command == scoo_pkg::CMD_CLEAR) begin
				cnt_q <= '0;
			end else if (in_acc && in_ch.command == scoo_pkg::CMD_APPEND && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_CMP) begin
				step_q <= '0;
			end else if (state_q == ST_MUL) begin
				step_q <= step_q + 3'd1;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == ST_FLUSH && load_out) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.command == scoo_pkg::CMD_APPEND && !full) begin
			mem[cnt_q[IDX_W-1:0]] <= '{row: in_ch.row, col: in_ch.col,
				re: in_ch.real_part, im: in_ch.imag_part};
		end
		rd_q <= mem[idx_d];
	end

	// Shared multiplier: ar*br, ai*bi, ar*bi, ai*br over four steps
	assign mul_a = step_q[0] ? ai_q : ar_q;
	assign mul_b = (step_q[0] ^ step_q[1]) ? rd_q.im : rd_q.re;

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_row_q     <= in_ch.row;
			a_col_q     <= in_ch.col;
			ar_q        <= in_ch.real_part;
			ai_q        <= in_ch.imag_part;
			resp_kind_q <= full ? scoo_pkg::KIND_FULL : scoo_pkg::KIND_STORED;
		end
		mul_s1 <= mul_a * mul_b;
		if (state_q == ST_MUL) begin
			case (step_q)
				3'd1: acc_re_q <= {mul_s1[63], mul_s1};
				3'd2: acc_re_q <= acc_re_q - {mul_s1[63], mul_s1};
				3'd3: acc_im_q <= {mul_s1[63], mul_s1};
				3'd4: acc_im_q <= acc_im_q + {mul_s1[63], mul_s1};
				default: ;
			endcase
		end
		if (state_q == ST_SAT) begin
			res_re_q <= shift_sat(acc_re_q);
			res_im_q <= shift_sat(acc_im_q);
		end
		if (pend_load) begin
			pend_col_q <= rd_q.col;
			pend_re_q  <= res_re_q;
			pend_im_q  <= res_im_q;
		end
		if (load_out) begin
			out_kind_q <= ld_kind;
			out_row_q  <= ld_row;
			out_col_q  <= ld_col;
			out_real_q <= ld_re;
			out_imag_q <= ld_im;
			out_last_q <= ld_last;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.kind     = out_kind_q;
	assign out_ch.out_row  = out_row_q;
	assign out_ch.out_col  = out_col_q;
	assign out_ch.out_real = out_real_q;
	assign out_ch.out_imag = out_imag_q;
	assign out_ch.last     = out_last_q;

endmodule

@@ src/scoo_checker.sv @@
`timescale 1ns / 1ps
`include "sparse_coo_complex_matmul_assert.svh"

module scoo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         in_command,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         out_kind,
	input logic [15:0]        out_row,
	input logic [15:0]        out_col,
	input logic signed [31:0] out_real,
	input logic signed [31:0] out_imag,
	input logic               out_last
);

	// Stalled result beat holds
	`SCOO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_row) && $stable(out_col) && $stable(out_real) && $stable(out_imag) && $stable(out_last), "stalled result beat changed")

	// Append answers are single beats
	`SCOO_ASSERT_SAME(a_resp_last, out_valid && out_kind != scoo_pkg::KIND_PRODUCT, out_last, "append answer without last")

	// Append answers carry zero fields
	`SCOO_ASSERT_SAME(a_resp_zero, out_valid && out_kind != scoo_pkg::KIND_PRODUCT, out_row == 16'd0 && out_col == 16'd0 && out_real == 32'sd0 && out_imag == 32'sd0, "append answer with nonzero fields")

	// An append keeps the input closed until its answer is issued
	`SCOO_ASSERT_NEXT(a_append_busy, in_valid && in_ready && in_command == scoo_pkg::CMD_APPEND, !in_ready, "input ready right after append")

endmodule

bind sparse_coo_complex_matmul scoo_checker u_scoo_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_command (in_ch.command),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_kind   (out_ch.kind),
	.out_row    (out_ch.out_row),
	.out_col    (out_ch.out_col),
	.out_real   (out_ch.out_real),
	.out_imag   (out_ch.out_imag),
	.out_last   (out_ch.last)
);
